// ===== sv/uxc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package uxc_pkg;

  // Operation codes carried in the opcode field
  localparam logic [1:0] OP_UTF8_DEC  = 2'd0;
  localparam logic [1:0] OP_UTF8_ENC  = 2'd1;
  localparam logic [1:0] OP_UTF16_DEC = 2'd2;
  localparam logic [1:0] OP_UTF16_ENC = 2'd3;

  localparam int POINT_W = 21;
  localparam int BYTE_W  = 8;
  localparam int UNIT_W  = 16;
  localparam int COUNT_W = 3;

  // Surrogate prefixes (top six bits of a UTF-16 unit)
  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  // Offset of the supplementary planes
  localparam logic [POINT_W-1:0] SUPP_BASE = 21'h10000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [BYTE_W-1:0]  utf8_in_0;
    logic [BYTE_W-1:0]  utf8_in_1;
    logic [BYTE_W-1:0]  utf8_in_2;
    logic [BYTE_W-1:0]  utf8_in_3;
    logic [UNIT_W-1:0]  utf16_in_0;
    logic [UNIT_W-1:0]  utf16_in_1;
    logic [POINT_W-1:0] point_in;
  } req_item_t;

  typedef struct packed {
    logic [POINT_W-1:0] point_out;
    logic [BYTE_W-1:0]  utf8_out_0;
    logic [BYTE_W-1:0]  utf8_out_1;
    logic [BYTE_W-1:0]  utf8_out_2;
    logic [BYTE_W-1:0]  utf8_out_3;
    logic [UNIT_W-1:0]  utf16_out_0;
    logic [UNIT_W-1:0]  utf16_out_1;
    logic [COUNT_W-1:0] unit_count;
  } rsp_item_t;

  // Load strobes from the pipeline control to the data registers
  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== sv/uxc_convert.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uxc_convert (
  input  uxc_pkg::req_item_t req,
  output uxc_pkg::rsp_item_t rsp
);
  import uxc_pkg::*;

  logic [BYTE_W-1:0]  b0;
  logic [5:0]         b1;
  logic [5:0]         b2;
  logic [5:0]         b3;
  logic [POINT_W-1:0] p;
  logic [19:0]        supp;

  assign b0   = req.utf8_in_0;
  assign b1   = req.utf8_in_1[5:0];
  assign b2   = req.utf8_in_2[5:0];
  assign b3   = req.utf8_in_3[5:0];
  assign p    = req.point_in;
  // Offset into the supplementary planes, wrapped to 20 bits
  assign supp = p[19:0] - SUPP_BASE[19:0];

  always_comb begin
    rsp = '0;
    unique case (req.opcode)
      OP_UTF8_DEC: begin
        if (!b0[7]) begin
          rsp.point_out  = {13'd0, b0};
          rsp.unit_count = 3'd1;
        end else if (b0[7:5] == 3'b110) begin
          rsp.point_out  = {10'd0, b0[4:0], b1};
          rsp.unit_count = 3'd2;
        end else if (b0[7:4] == 4'b1110) begin
          rsp.point_out  = {5'd0, b0[3:0], b1, b2};
          rsp.unit_count = 3'd3;
        end else begin
          // any other lead byte is read as a four-byte lead
          rsp.point_out  = {b0[2:0], b1, b2, b3};
          rsp.unit_count = 3'd4;
        end
      end
      OP_UTF8_ENC: begin
        if (p[20:7] == '0) begin
          rsp.utf8_out_0 = p[7:0];
          rsp.unit_count = 3'd1;
        end else if (p[20:11] == '0) begin
          rsp.utf8_out_0 = {3'b110, p[10:6]};
          rsp.utf8_out_1 = {2'b10, p[5:0]};
          rsp.unit_count = 3'd2;
        end else if (p[20:16] == '0) begin
          rsp.utf8_out_0 = {4'b1110, p[15:12]};
          rsp.utf8_out_1 = {2'b10, p[11:6]};
          rsp.utf8_out_2 = {2'b10, p[5:0]};
          rsp.unit_count = 3'd3;
        end else begin
          rsp.utf8_out_0 = {5'b11110, p[20:18]};
          rsp.utf8_out_1 = {2'b10, p[17:12]};
          rsp.utf8_out_2 = {2'b10, p[11:6]};
          rsp.utf8_out_3 = {2'b10, p[5:0]};
          rsp.unit_count = 3'd4;
        end
      end
      OP_UTF16_DEC: begin
        if (req.utf16_in_0[15:10] == HI_SURR_TAG) begin
          rsp.point_out  = SUPP_BASE
                         + {1'b0, req.utf16_in_0[9:0], req.utf16_in_1[9:0]};
          rsp.unit_count = 3'd2;
        end else begin
          rsp.point_out  = {5'd0, req.utf16_in_0};
          rsp.unit_count = 3'd1;
        end
      end
      OP_UTF16_ENC: begin
        if (p[20:16] == '0) begin
          rsp.utf16_out_0 = p[15:0];
          rsp.unit_count  = 3'd1;
        end else begin
          rsp.utf16_out_0 = {HI_SURR_TAG, supp[19:10]};
          rsp.utf16_out_1 = {LO_SURR_TAG, supp[9:0]};
          rsp.unit_count  = 3'd2;
        end
      end
      default: rsp = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/uxc_pipe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uxc_pipe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output uxc_pkg::pipe_ctl_t ctl
);
  import uxc_pkg::*;

  logic s1_valid;
  logic s1_valid_next;
  logic s2_valid;
  logic s2_valid_next;
  logic s2_ready;
  logic s1_ready;
  logic rsp_take;
  logic s1_load;
  logic s2_load;

  assign rsp_valid = s2_valid;
  assign rsp_take  = s2_valid && !rsp_stall;
  assign s2_ready  = !s2_valid || !rsp_stall;
  assign s2_load   = s1_valid && s2_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign req_stall = !s1_ready;
  assign s1_load   = req_valid && s1_ready;
  assign ctl       = '{s1_load: s1_load, s2_load: s2_load};

  always_comb begin
    s1_valid_next = s1_valid;
    if (s1_load) begin
      s1_valid_next = 1'b1;
    end else if (s2_load) begin
      s1_valid_next = 1'b0;
    end
    s2_valid_next = s2_valid;
    if (s2_load) begin
      s2_valid_next = 1'b1;
    end else if (rsp_take) begin
      s2_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
      s2_valid <= s2_valid_next;
    end
  end

  // Stall upstream only while the input stage holds an item that cannot move
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (s1_valid && s2_valid && rsp_stall))
    else $error("input stalled with room in the pipeline");

  // Never load the result register from an empty input stage
  a_s2_load_from_full: assert property (@(posedge clk) disable iff (rst)
    s2_load |-> s1_valid)
    else $error("result register loaded from an empty stage");

  // An item held in the input stage is not dropped
  a_s1_no_drop: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_load) |=> s1_valid)
    else $error("input stage item lost");

  // A result not taken downstream stays presented
  a_s2_no_drop: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && rsp_stall) |=> (s2_valid && !$past(s2_load)))
    else $error("stalled result overwritten or lost");

endmodule

`default_nettype wire

// ===== sv/unicode_utf8_utf16_transcoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 / UTF-16 code point transcoder. Each beat on the req channel carries an
// opcode (UTF-8 decode, UTF-8 encode, UTF-16 decode, UTF-16 encode) and all
// operand fields; each produces exactly one beat on the rsp channel with the
// decoded code point or the encoded bytes/units, plus the number of bytes or
// units consumed or produced. Fields an operation does not produce read zero.
// Continuation bytes and trailing low surrogates are not validated; any UTF-8
// lead byte that is not a 1, 2 or 3 byte lead is taken as a four-byte lead, and
// UTF-16 encode of points above 0x10FFFF wraps in 20 bits. A req beat passes
// one input register, the conversion logic, and one result register, which
// drives rsp_valid. Throughput is one beat per clock while rsp_stall is low;
// req_stall rises only when both registers are full and rsp_stall is high.
module unicode_utf8_utf16_transcoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  uxc_pkg::req_item_t req_item,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output uxc_pkg::rsp_item_t rsp_item
);
  import uxc_pkg::*;

  pipe_ctl_t ctl;
  req_item_t in_reg;
  rsp_item_t conv;
  rsp_item_t out_reg;

  // Handshake control for the two register stages
  uxc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctl       (ctl)
  );

  // Capture the operand beat; hold it while the result stage is blocked
  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      in_reg <= req_item;
    end
  end

  // All four conversions are combinational logic between the two registers
  uxc_convert u_convert (
    .req (in_reg),
    .rsp (conv)
  );

  // Result register; hold the beat steady while the consumer stalls
  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      out_reg <= conv;
    end
  end

  assign rsp_item = out_reg;

endmodule

`default_nettype wire

// ===== verif/utf_conversion_checker.sv =====
`timescale 1ns / 1ps

module utf_conversion_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  uxc_pkg::req_item_t req_item,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  uxc_pkg::rsp_item_t rsp_item,
  output int                 fail_count,
  output int                 pending_count
);
  import uxc_pkg::*;

  localparam int SHOWN_MISMATCHES = 10;

  rsp_item_t expected_conversions[$];
  int        mismatch_count = 0;

  initial pending_count = 0;
  assign fail_count = mismatch_count;

  function automatic rsp_item_t predict_conversion(input req_item_t rq);
    rsp_item_t          r;
    logic [7:0]         lead;
    logic [5:0]         c1, c2, c3;
    logic [POINT_W-1:0] p;
    logic [POINT_W-1:0] offs;
    r    = '0;
    lead = rq.utf8_in_0;
    c1   = rq.utf8_in_1[5:0];
    c2   = rq.utf8_in_2[5:0];
    c3   = rq.utf8_in_3[5:0];
    p    = rq.point_in;
    offs = p - SUPP_BASE;
    case (rq.opcode)
      OP_UTF8_DEC: begin
        if (!lead[7]) begin
          r.point_out  = {13'd0, lead};
          r.unit_count = 3'd1;
        end else if (lead[7:5] == 3'b110) begin
          r.point_out  = {10'd0, lead[4:0], c1};
          r.unit_count = 3'd2;
        end else if (lead[7:4] == 4'b1110) begin
          r.point_out  = {5'd0, lead[3:0], c1, c2};
          r.unit_count = 3'd3;
        end else begin
          // anything else counts as a four-byte lead
          r.point_out  = {lead[2:0], c1, c2, c3};
          r.unit_count = 3'd4;
        end
      end
      OP_UTF8_ENC: begin
        if (p <= 21'h7f) begin
          r.utf8_out_0 = p[7:0];
          r.unit_count = 3'd1;
        end else if (p <= 21'h7ff) begin
          r.utf8_out_0 = {3'b110, p[10:6]};
          r.utf8_out_1 = {2'b10, p[5:0]};
          r.unit_count = 3'd2;
        end else if (p <= 21'hffff) begin
          r.utf8_out_0 = {4'b1110, p[15:12]};
          r.utf8_out_1 = {2'b10, p[11:6]};
          r.utf8_out_2 = {2'b10, p[5:0]};
          r.unit_count = 3'd3;
        end else begin
          r.utf8_out_0 = {5'b11110, p[20:18]};
          r.utf8_out_1 = {2'b10, p[17:12]};
          r.utf8_out_2 = {2'b10, p[11:6]};
          r.utf8_out_3 = {2'b10, p[5:0]};
          r.unit_count = 3'd4;
        end
      end
      OP_UTF16_DEC: begin
        if (rq.utf16_in_0[15:10] == HI_SURR_TAG) begin
          r.point_out  = SUPP_BASE + {1'b0, rq.utf16_in_0[9:0], rq.utf16_in_1[9:0]};
          r.unit_count = 3'd2;
        end else begin
          r.point_out  = {5'd0, rq.utf16_in_0};
          r.unit_count = 3'd1;
        end
      end
      default: begin
        if (p <= 21'hffff) begin
          r.utf16_out_0 = p[15:0];
          r.unit_count  = 3'd1;
        end else begin
          // wrap in 20 bits above the last plane
          r.utf16_out_0 = {HI_SURR_TAG, offs[19:10]};
          r.utf16_out_1 = {LO_SURR_TAG, offs[9:0]};
          r.unit_count  = 3'd2;
        end
      end
    endcase
    return r;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCHES)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_conversions.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_MISMATCHES)
            $display("%0t: result beat with nothing outstanding: %0h", $time, rsp_item);
        end else begin
          want = expected_conversions.pop_front();
          flag_field("point_out",   32'(want.point_out),   32'(rsp_item.point_out));
          flag_field("utf8_out_0",  32'(want.utf8_out_0),  32'(rsp_item.utf8_out_0));
          flag_field("utf8_out_1",  32'(want.utf8_out_1),  32'(rsp_item.utf8_out_1));
          flag_field("utf8_out_2",  32'(want.utf8_out_2),  32'(rsp_item.utf8_out_2));
          flag_field("utf8_out_3",  32'(want.utf8_out_3),  32'(rsp_item.utf8_out_3));
          flag_field("utf16_out_0", 32'(want.utf16_out_0), 32'(rsp_item.utf16_out_0));
          flag_field("utf16_out_1", 32'(want.utf16_out_1), 32'(rsp_item.utf16_out_1));
          flag_field("unit_count",  32'(want.unit_count),  32'(rsp_item.unit_count));
        end
      end
      if (req_valid && !req_stall)
        expected_conversions.push_back(predict_conversion(req_item));
      pending_count <= expected_conversions.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import uxc_pkg::*;

  localparam int RANDOM_BEATS = 1750;
  // Idle odds per cycle, in percent, for both sender and receiver
  localparam int IDLE_PCT     = 24;
  // Beats of the random part that run with neither side idling
  localparam int CALM_FIRST   = 700;
  localparam int CALM_LAST    = 999;
  localparam int DRAIN_CYCLES = 10;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req_item = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp_item;
  int        fail_count;
  int        pending_count;
  // High while neither side may idle
  logic      calm = 1'b0;

  always #5 clk = ~clk;

  unicode_utf8_utf16_transcoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  utf_conversion_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_item      (req_item),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp_item      (rsp_item),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Stall the result channel at random, except in the calm stretch
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Fill every field with noise; an operation picks the fields it uses
  function automatic req_item_t random_fields();
    req_item_t it;
    it.opcode     = 2'($urandom_range(3));
    it.utf8_in_0  = 8'($urandom);
    it.utf8_in_1  = 8'($urandom);
    it.utf8_in_2  = 8'($urandom);
    it.utf8_in_3  = 8'($urandom);
    it.utf16_in_0 = 16'($urandom);
    it.utf16_in_1 = 16'($urandom);
    it.point_in   = 21'($urandom);
    return it;
  endfunction

  // Build a directed beat: the word holds the four UTF-8 bytes, the two
  // UTF-16 units, or the code point, depending on the operation
  function automatic req_item_t make_beat(input logic [1:0] op, input logic [31:0] word);
    req_item_t it;
    it        = random_fields();
    it.opcode = op;
    case (op)
      OP_UTF8_DEC:  {it.utf8_in_0, it.utf8_in_1, it.utf8_in_2, it.utf8_in_3} = word;
      OP_UTF16_DEC: {it.utf16_in_0, it.utf16_in_1} = word;
      default:      it.point_in = word[POINT_W-1:0];
    endcase
    return it;
  endfunction

  // Spread code points over every length class, the surrogate block,
  // the range beyond the last plane, and the exact class boundaries
  function automatic logic [POINT_W-1:0] pick_point();
    logic [POINT_W-1:0] p;
    case ($urandom_range(6))
      0: p = 21'($urandom_range(21'h7f, 0));
      1: p = 21'($urandom_range(21'h7ff, 21'h80));
      2: p = 21'($urandom_range(21'hffff, 21'h800));
      3: p = 21'($urandom_range(21'hdfff, 21'hd800));
      4: p = 21'($urandom_range(21'h10ffff, 21'h10000));
      5: p = 21'($urandom_range(21'h1fffff, 21'h110000));
      default: begin
        case ($urandom_range(9))
          0: p = 21'h0;
          1: p = 21'h7f;
          2: p = 21'h80;
          3: p = 21'h7ff;
          4: p = 21'h800;
          5: p = 21'hffff;
          6: p = 21'h10000;
          7: p = 21'h10ffff;
          8: p = 21'h110000;
          default: p = 21'h1fffff;
        endcase
      end
    endcase
    return p;
  endfunction

  // Mostly well-formed sequences with random content; the rest is raw noise,
  // which covers stray continuation leads, bad leads and lone low surrogates
  function automatic req_item_t random_beat();
    req_item_t it;
    it = random_fields();
    if ($urandom_range(99) < 75) begin
      case (it.opcode)
        OP_UTF8_DEC: begin
          case ($urandom_range(3))
            0: it.utf8_in_0 = {1'b0, 7'($urandom)};
            1: it.utf8_in_0 = {3'b110, 5'($urandom)};
            2: it.utf8_in_0 = {4'b1110, 4'($urandom)};
            default: it.utf8_in_0 = {5'b11110, 3'($urandom)};
          endcase
          it.utf8_in_1 = {2'b10, 6'($urandom)};
          it.utf8_in_2 = {2'b10, 6'($urandom)};
          it.utf8_in_3 = {2'b10, 6'($urandom)};
        end
        OP_UTF16_DEC: begin
          if ($urandom_range(99) < 80) begin
            it.utf16_in_0 = {HI_SURR_TAG, 10'($urandom)};
            it.utf16_in_1 = {LO_SURR_TAG, 10'($urandom)};
          end else begin
            it.utf16_in_0 = {LO_SURR_TAG, 10'($urandom)};
          end
        end
        default: it.point_in = pick_point();
      endcase
    end
    return it;
  endfunction

  // Offer one beat after an optional random gap, and hold it until accepted
  task automatic send_beat(input req_item_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  initial begin
    int i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // UTF-8 decode: each lead class, a continuation byte as lead, an 0xFF lead
    send_beat(make_beat(OP_UTF8_DEC, 32'h00000000));
    send_beat(make_beat(OP_UTF8_DEC, 32'h7fffffff));
    send_beat(make_beat(OP_UTF8_DEC, 32'hc2a90000));
    send_beat(make_beat(OP_UTF8_DEC, 32'he282ac00));
    send_beat(make_beat(OP_UTF8_DEC, 32'hf09f9880));
    send_beat(make_beat(OP_UTF8_DEC, 32'hf7bfbfbf));
    send_beat(make_beat(OP_UTF8_DEC, 32'h80ffffff));
    send_beat(make_beat(OP_UTF8_DEC, 32'hff000000));
    // UTF-8 encode: inclusive class limits, a surrogate value, the top point
    send_beat(make_beat(OP_UTF8_ENC, 32'h7f));
    send_beat(make_beat(OP_UTF8_ENC, 32'h80));
    send_beat(make_beat(OP_UTF8_ENC, 32'h7ff));
    send_beat(make_beat(OP_UTF8_ENC, 32'h800));
    send_beat(make_beat(OP_UTF8_ENC, 32'hd800));
    send_beat(make_beat(OP_UTF8_ENC, 32'hffff));
    send_beat(make_beat(OP_UTF8_ENC, 32'h10000));
    send_beat(make_beat(OP_UTF8_ENC, 32'h1fffff));
    // UTF-16 decode: plain unit, a pair, an unchecked low unit, a lone low
    send_beat(make_beat(OP_UTF16_DEC, 32'h0041ffff));
    send_beat(make_beat(OP_UTF16_DEC, 32'hd83dde00));
    send_beat(make_beat(OP_UTF16_DEC, 32'hdbffffff));
    send_beat(make_beat(OP_UTF16_DEC, 32'hdc000000));
    // UTF-16 encode: last BMP point, first and last pair, wrap beyond
    send_beat(make_beat(OP_UTF16_ENC, 32'hffff));
    send_beat(make_beat(OP_UTF16_ENC, 32'h10000));
    send_beat(make_beat(OP_UTF16_ENC, 32'h10ffff));
    send_beat(make_beat(OP_UTF16_ENC, 32'h110000));
    send_beat(make_beat(OP_UTF16_ENC, 32'h1fffff));

    for (i = 0; i < RANDOM_BEATS; i++) begin
      calm <= (i >= CALM_FIRST) && (i <= CALM_LAST);
      send_beat(random_beat());
    end
    req_valid <= 1'b0;
    calm      <= 1'b0;

    // Let the count catch up with the last accepted beat, then drain
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
